// File: rtl/lpt_pkg.sv
// shared types, sizes and codes for the length prefixed packet transmit buffer
// no dependencies
`default_nettype none

package lpt_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_LEN     = 128;
    localparam int NSLOTS      = QUEUE_DEPTH + 2;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 8;
    localparam int POS_W   = LEN_W + 1;
    localparam int SLOT_W  = $clog2(NSLOTS);
    localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = $clog2(NSLOTS * MAX_LEN);
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [2:0] ST_TAKEN    = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_BYTE_OUT = 3'd4;
    localparam logic [2:0] ST_IDLE     = 3'd5;

    localparam logic REG_QUEUE_LIMIT = 1'b0;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [BYTE_W-1:0] out_byte;
        logic              frame_end;
    } out_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_read;
    } ctl_stat_t;

endpackage

`default_nettype wire

// File: rtl/lpt_ctrl.sv
// sequencing state machine for the packet transmit buffer
// depends on lpt_pkg
`default_nettype none

module lpt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output lpt_pkg::ctl_cmd_t       ctl,
    input  wire lpt_pkg::ctl_stat_t stat
);
    import lpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.need_read ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign ctl.load = start && (state_reg == S_IDLE);
    assign ctl.exec = (state_reg == S_EXEC);
    assign ctl.emit = (state_reg == S_OUT);

endmodule

`default_nettype wire

// File: rtl/lpt_dp.sv
// datapath: packet storage, waiting queue, slot bookkeeping and result register
// depends on lpt_pkg
`default_nettype none

module lpt_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lpt_pkg::ctl_cmd_t               ctl,
    output lpt_pkg::ctl_stat_t                   stat,
    input  wire lpt_pkg::in_t                    item,
    input  wire logic [lpt_pkg::LIMIT_W-1:0]     queue_limit,
    output lpt_pkg::out_t                        result,
    output logic                                 done
);
    import lpt_pkg::*;

    localparam int SUM_W = HEAD_W + 1;

    logic [BYTE_W-1:0] mem [NSLOTS*MAX_LEN];
    logic [BYTE_W-1:0] mem_q_reg;

    in_t               cmd_reg;
    logic [HEAD_W-1:0]  ring_head_reg,    ring_head_next;
    logic [COUNT_W-1:0] ring_count_reg,   ring_count_next;
    logic [SLOT_W-1:0]  asm_slot_reg,     asm_slot_next;
    logic [LEN_W-1:0]   asm_count_reg,    asm_count_next;
    logic               asm_too_long_reg, asm_too_long_next;
    logic [SLOT_W-1:0]  send_slot_reg,    send_slot_next;
    logic [POS_W-1:0]   send_pos_reg,     send_pos_next;
    logic               sending_reg,      sending_next;
    logic [NSLOTS-1:0]  used_reg,         used_next;
    logic [SLOT_W-1:0]  order_ring_reg [QUEUE_DEPTH];
    logic [SLOT_W-1:0]  order_ring_next [QUEUE_DEPTH];
    logic [LEN_W-1:0]   slot_len_reg [NSLOTS];
    logic [LEN_W-1:0]   slot_len_next [NSLOTS];
    out_t               result_reg,       result_next;
    logic               done_reg,         done_next;
    logic               hdr_sel_reg,      hdr_sel_next;
    logic [BYTE_W-1:0]  hdr_byte_reg,     hdr_byte_next;
    logic               fend_reg,         fend_next;

    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [7:0]         lim;
    logic               store;
    logic [LEN_W-1:0]   cnt_inc;
    logic               too_long;
    logic               drop;
    logic [HEAD_W-1:0]  head_inc;
    logic [HEAD_W-1:0]  head1;
    logic [COUNT_W-1:0] count1;
    logic [SUM_W-1:0]   tail_sum;
    logic [HEAD_W-1:0]  tail;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic               pop;
    logic               active;
    logic [SLOT_W-1:0]  slot_s;
    logic [POS_W-1:0]   pos_s;
    logic [LEN_W-1:0]   len_s;
    logic               fend_s;

    // effective limit, clamped to 1..QUEUE_DEPTH
    always_comb
    begin
        lim = 8'(queue_limit);
        if (lim == 8'd0)
        begin
            lim = 8'd1;
        end
        if (lim > 8'(QUEUE_DEPTH))
        begin
            lim = 8'(QUEUE_DEPTH);
        end
    end

    assign head_slot = order_ring_reg[ring_head_reg];
    assign head_inc  = (ring_head_reg == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : ring_head_reg + 1'b1;

    assign store    = (asm_count_reg < LEN_W'(MAX_LEN));
    assign cnt_inc  = asm_count_reg + LEN_W'(store);
    assign too_long = asm_too_long_reg || !store;
    assign drop     = (8'(ring_count_reg) >= lim);
    assign head1    = drop ? head_inc : ring_head_reg;
    assign count1   = drop ? ring_count_reg - 1'b1 : ring_count_reg;
    assign tail_sum = SUM_W'(head1) + SUM_W'(count1);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);

    assign pop    = !sending_reg && (ring_count_reg != '0);
    assign active = sending_reg || pop;
    assign slot_s = pop ? head_slot : send_slot_reg;
    assign pos_s  = pop ? '0 : send_pos_reg;
    assign len_s  = slot_len_reg[slot_s];
    assign fend_s = ((POS_W + 1)'(pos_s) >= (POS_W + 1)'(len_s) + 1'b1);

    always_comb
    begin
        ring_head_next    = ring_head_reg;
        ring_count_next   = ring_count_reg;
        asm_slot_next     = asm_slot_reg;
        asm_count_next    = asm_count_reg;
        asm_too_long_next = asm_too_long_reg;
        send_slot_next    = send_slot_reg;
        send_pos_next     = send_pos_reg;
        sending_next      = sending_reg;
        used_next         = used_reg;
        order_ring_next   = order_ring_reg;
        slot_len_next     = slot_len_reg;
        result_next       = result_reg;
        done_next         = 1'b0;
        hdr_sel_next      = hdr_sel_reg;
        hdr_byte_next     = hdr_byte_reg;
        fend_next         = fend_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = ADDR_W'(asm_slot_reg) * ADDR_W'(MAX_LEN) + ADDR_W'(asm_count_reg);
        mem_raddr         = ADDR_W'(slot_s) * ADDR_W'(MAX_LEN) + ADDR_W'(pos_s - 2'd2);
        stat.need_read    = 1'b0;

        if (ctl.exec)
        begin
            if (cmd_reg.command == CMD_WRITE)
            begin
                mem_we    = store;
                done_next = 1'b1;
                result_next = '{status: ST_TAKEN, out_byte: '0, frame_end: 1'b0};
                asm_count_next    = cnt_inc;
                asm_too_long_next = too_long;
                if (cmd_reg.last)
                begin
                    asm_count_next    = '0;
                    asm_too_long_next = 1'b0;
                    if (too_long)
                    begin
                        result_next.status = ST_REJECTED;
                    end
                    else
                    begin
                        result_next.status = drop ? ST_DROPPED : ST_QUEUED;
                        for (int i = 0; i < NSLOTS; i++)
                        begin
                            if (drop && (head_slot == SLOT_W'(i)))
                            begin
                                used_next[i] = 1'b0;
                            end
                            if (asm_slot_reg == SLOT_W'(i))
                            begin
                                used_next[i]     = 1'b1;
                                slot_len_next[i] = cnt_inc;
                            end
                        end
                        for (int i = 0; i < QUEUE_DEPTH; i++)
                        begin
                            if (tail == HEAD_W'(i))
                            begin
                                order_ring_next[i] = asm_slot_reg;
                            end
                        end
                        ring_head_next  = head1;
                        ring_count_next = count1 + 1'b1;
                        asm_slot_next   = free_slot;
                    end
                end
            end
            else
            begin
                if (pop)
                begin
                    ring_head_next  = head_inc;
                    ring_count_next = ring_count_reg - 1'b1;
                end
                if (!active)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_IDLE, out_byte: '0, frame_end: 1'b0};
                end
                else
                begin
                    stat.need_read = 1'b1;
                    mem_re         = (pos_s >= POS_W'(2));
                    hdr_sel_next   = (pos_s < POS_W'(2));
                    // length high byte is always zero for 8-bit lengths
                    hdr_byte_next  = (pos_s == '0) ? '0 : len_s;
                    fend_next      = fend_s;
                    send_slot_next = slot_s;
                    if (fend_s)
                    begin
                        sending_next  = 1'b0;
                        send_pos_next = '0;
                        for (int i = 0; i < NSLOTS; i++)
                        begin
                            if (slot_s == SLOT_W'(i))
                            begin
                                used_next[i] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        sending_next  = 1'b1;
                        send_pos_next = pos_s + 1'b1;
                    end
                end
            end
        end

        if (ctl.emit)
        begin
            done_next   = 1'b1;
            result_next = '{status: ST_BYTE_OUT,
                            out_byte: hdr_sel_reg ? hdr_byte_reg : mem_q_reg,
                            frame_end: fend_reg};
        end
    end

    // lowest slot neither waiting nor being sent
    always_comb
    begin
        free_slot = '0;
        for (int i = NSLOTS - 1; i >= 0; i--)
        begin
            if (!used_next[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd_reg.data_byte;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= item;
        end
        order_ring_reg <= order_ring_next;
        slot_len_reg   <= slot_len_next;
        result_reg     <= result_next;
        hdr_sel_reg    <= hdr_sel_next;
        hdr_byte_reg   <= hdr_byte_next;
        fend_reg       <= fend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_head_reg    <= '0;
            ring_count_reg   <= '0;
            asm_slot_reg     <= '0;
            asm_count_reg    <= '0;
            asm_too_long_reg <= 1'b0;
            send_slot_reg    <= '0;
            send_pos_reg     <= '0;
            sending_reg      <= 1'b0;
            used_reg         <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            ring_head_reg    <= ring_head_next;
            ring_count_reg   <= ring_count_next;
            asm_slot_reg     <= asm_slot_next;
            asm_count_reg    <= asm_count_next;
            asm_too_long_reg <= asm_too_long_next;
            send_slot_reg    <= send_slot_next;
            send_pos_reg     <= send_pos_next;
            sending_reg      <= sending_next;
            used_reg         <= used_next;
            done_reg         <= done_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// File: rtl/length_prefixed_packet_tx_fifo_unit.sv
// top level of the length prefixed packet transmit buffer: queue_limit register and apb port
// depends on lpt_pkg, lpt_ctrl, lpt_dp
//
// channel   signals                                      transfer
// item      start, busy, item                            start high while busy low
// result    done, result                                 done high, one cycle, no stall
// config    psel, penable, pwrite, paddr, pwdata,        psel, penable, pwrite, pready high
//           prdata, pready
//
// a write item or an idle drain passes through the exec state before its result strobe
// a drain that emits a byte also passes through the out state, which covers the registered packet memory read
// a new item may be started in the cycle its predecessor's result is shown
// asynchronous active low reset, no clearing pass; results cannot be stalled
`default_nettype none

module length_prefixed_packet_tx_fifo_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire lpt_pkg::in_t        item,
    output logic                     done,
    output lpt_pkg::out_t            result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import lpt_pkg::*;

    logic [LIMIT_W-1:0] queue_limit_reg;
    ctl_cmd_t           ctl;
    ctl_stat_t          stat;
    logic               reg_hit;

    assign reg_hit = (paddr[2] == REG_QUEUE_LIMIT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? 32'(queue_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            queue_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    lpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .stat  (stat)
    );

    lpt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .item        (item),
        .queue_limit (queue_limit_reg),
        .result      (result),
        .done        (done)
    );

endmodule

`default_nettype wire

// File: rtl/lpt_checker.sv
// port level checks for the packet transmit buffer, bound to the top level
// depends on lpt_pkg and length_prefixed_packet_tx_fifo_unit
`default_nettype none

module lpt_port_checks (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire lpt_pkg::out_t result
);
    import lpt_pkg::*;

    // accepted item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // a result never shows while an item is still in work
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // one result per item, never two in a row
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    // only a stream byte carries data or a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_BYTE_OUT)) |-> (result.out_byte == '0 && !result.frame_end))
        else $error("nonzero byte or frame end without a byte out");

    // status codes above idle never appear
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= ST_IDLE))
        else $error("undefined status code");

endmodule

bind length_prefixed_packet_tx_fifo_unit lpt_port_checks u_lpt_port_checks (.*);

`default_nettype wire
